/* design/pendulum_swing_up_kicker_macros.svh */
// ----------------------------------------------------------------------------
// Pendulum swing-up kicker assertion macros
// Concurrent assertion wrappers that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef PENDULUM_SWING_UP_KICKER_MACROS_SVH
`define PENDULUM_SWING_UP_KICKER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define PSUK_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define PSUK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define PSUK_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define PSUK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* design/psuk_pkg.sv */
// ----------------------------------------------------------------------------
// Pendulum swing-up kicker package
// Shared types, register indexes and reset values of the kicker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psuk_pkg;

	localparam int ENCODER_BITS_DEF = 16;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_FIRST_KICK     = 3'd0,
		REG_CROSS_KICK     = 3'd1,
		REG_TOP_THRESHOLD  = 3'd2,
		REG_WRAP_THRESHOLD = 3'd3,
		REG_MOTOR_IDLE     = 3'd4
	} reg_idx_t;

	localparam logic [15:0] FIRST_KICK_RST     = 16'd250;
	localparam logic [15:0] CROSS_KICK_RST     = 16'd100;
	localparam logic [15:0] TOP_THRESHOLD_RST  = 16'd1180;
	localparam logic [15:0] WRAP_THRESHOLD_RST = 16'd2400;
	localparam logic [7:0]  MOTOR_IDLE_RST     = 8'd8;

	typedef struct packed {
		logic [15:0] first_kick;
		logic [15:0] cross_kick;
		logic [15:0] top_threshold;
		logic [15:0] wrap_threshold;
		logic [7:0]  motor_idle_code;
	} cfg_t;

	// Mode flags of the swing-up sequence.
	typedef struct packed {
		logic first_pending;
		logic kick_positive;
		logic finished;
	} mode_t;

	localparam mode_t MODE_RST = '{first_pending: 1'b1, kick_positive: 1'b1, finished: 1'b0};

endpackage

/* design/psuk_step.sv */
// ----------------------------------------------------------------------------
// Pendulum swing-up kicker step logic
// Wrapped encoder offset, kick decision and next mode for one sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psuk_step #(
	parameter int ENCODER_BITS = psuk_pkg::ENCODER_BITS_DEF,
	localparam int OFF_W = ENCODER_BITS + 2
) (
	input  psuk_pkg::cfg_t            cfg,
	input  psuk_pkg::mode_t           mode,
	input  logic signed [OFF_W-1:0]   last_offset,
	input  logic                      action,
	input  logic [7:0]                motor_state,
	input  logic [15:0]               encoder_position,
	input  logic [15:0]               bottom_position,
	input  logic signed [31:0]        motor_position,
	output psuk_pkg::mode_t           mode_nxt,
	output logic                      offset_upd,
	output logic signed [OFF_W-1:0]   offset,
	output logic                      move_command,
	output logic signed [31:0]        target_position,
	output logic                      switch_mode
);
	import psuk_pkg::*;

	// Only the low encoder bits that the ports carry take part.
	localparam int USE_W = (ENCODER_BITS < 16) ? ENCODER_BITS : 16;
	localparam int CMP_W = (OFF_W > 16) ? OFF_W : 16;
	localparam logic signed [OFF_W-1:0] SPAN = {2'b01, {ENCODER_BITS{1'b0}}};

	logic [USE_W-1:0]        enc_u;
	logic [USE_W-1:0]        bot_u;
	logic [USE_W-1:0]        up_gap;
	logic [USE_W-1:0]        dn_gap;
	logic signed [OFF_W-1:0] diff;
	logic signed [OFF_W-1:0] mag_s;
	logic [CMP_W-1:0]        mag;
	logic                    idle;
	logic                    sign_flip;
	logic [31:0]             mpos;

	assign enc_u  = encoder_position[USE_W-1:0];
	assign bot_u  = bottom_position[USE_W-1:0];
	assign up_gap = enc_u - bot_u;
	assign dn_gap = bot_u - enc_u;
	assign diff   = $signed(OFF_W'(enc_u)) - $signed(OFF_W'(bot_u));
	assign mpos   = $unsigned(motor_position);

	always_comb begin
		// A gap wider than the wrap threshold means the encoder rolled over.
		if (enc_u > bot_u) begin
			offset = (CMP_W'(up_gap) > CMP_W'(cfg.wrap_threshold)) ? diff - SPAN : diff;
		end else begin
			offset = (CMP_W'(dn_gap) > CMP_W'(cfg.wrap_threshold)) ? diff + SPAN : diff;
		end
	end

	assign mag_s     = offset[OFF_W-1] ? -offset : offset;
	assign mag       = CMP_W'($unsigned(mag_s));
	assign idle      = (motor_state == cfg.motor_idle_code);
	assign sign_flip = (offset[OFF_W-1] != last_offset[OFF_W-1]);

	always_comb begin
		mode_nxt        = mode;
		offset_upd      = 1'b0;
		move_command    = 1'b0;
		target_position = '0;
		switch_mode     = 1'b0;
		if (action) begin
			mode_nxt = MODE_RST;
		end else if (mode.finished) begin
			mode_nxt = mode;
		end else if (mode.first_pending) begin
			if (idle) begin
				mode_nxt.first_pending = 1'b0;
				offset_upd             = 1'b1;
				move_command           = 1'b1;
				target_position        = mode.kick_positive
					? $signed(mpos - 32'(cfg.first_kick))
					: $signed(mpos + 32'(cfg.first_kick));
			end
		end else if (mag > CMP_W'(cfg.top_threshold)) begin
			mode_nxt.finished = 1'b1;
			switch_mode       = 1'b1;
		end else begin
			offset_upd = 1'b1;
			if (sign_flip) begin
				// The direction alternates on every crossing, kick or not.
				mode_nxt.kick_positive = !mode.kick_positive;
				if (idle) begin
					move_command    = 1'b1;
					target_position = mode.kick_positive
						? $signed(mpos + 32'(cfg.cross_kick))
						: $signed(mpos - 32'(cfg.cross_kick));
				end
			end
		end
	end

endmodule

/* design/pendulum_swing_up_kicker.sv */
// ----------------------------------------------------------------------------
// Pendulum swing-up kicker
// Issues motor kick moves that pump an inverted pendulum up to the top.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries one control sample (or a restart
// action) on in_valid / in_stall with the fields as separate ports. Every
// input transaction yields exactly one output transaction on out_valid /
// out_stall: a move command with its absolute target, or a hand-over flag,
// or an all-zero result.
// The sample is captured in the input register when it is accepted, and the
// result register is loaded from it when the stage advances. Throughput is
// one transaction per clock while out_stall is low; the only loop is the
// mode and last-offset state, updated in the same cycle as the result.
// When the receiver stalls, the result register holds its transaction and
// one further sample still enters the input register; only then does
// in_stall rise, combinationally following out_stall.
// Reset clears both valid flags, restores the mode flags (first kick
// pending, positive direction, not finished), clears the last offset and
// loads the register defaults. The user must write the registers through
// cfg_write, cfg_index and cfg_data only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pendulum_swing_up_kicker_macros.svh"

module pendulum_swing_up_kicker #(
	parameter int ENCODER_BITS = psuk_pkg::ENCODER_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration write port.
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// Sample channel.
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic [7:0]         motor_state,
	input  logic [15:0]        encoder_position,
	input  logic [15:0]        bottom_position,
	input  logic signed [31:0] motor_position,
	// Result channel.
	output logic               out_valid,
	input  logic               out_stall,
	output logic               move_command,
	output logic signed [31:0] target_position,
	output logic               switch_mode
);
	import psuk_pkg::*;

	localparam int OFF_W = ENCODER_BITS + 2;

	// Configuration registers.
	cfg_t cfg_q;

	// Swing-up state.
	mode_t                   mode_q;
	logic signed [OFF_W-1:0] last_offset_q;

	// Input register stage.
	logic               valid_s1;
	logic               action_s1;
	logic [7:0]         motor_state_s1;
	logic [15:0]        encoder_position_s1;
	logic [15:0]        bottom_position_s1;
	logic signed [31:0] motor_position_s1;

	// Result register.
	logic               out_valid_q;
	logic               move_command_q;
	logic signed [31:0] target_position_q;
	logic               switch_mode_q;

	// Step logic outputs.
	mode_t                   mode_nxt;
	logic                    offset_upd;
	logic signed [OFF_W-1:0] offset;
	logic                    res_move;
	logic signed [31:0]      res_target;
	logic                    res_switch;

	logic in_accept;
	logic adv;

	// The stage advances when it holds a sample and the result register is empty or being drained.
	assign adv       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_kick      <= FIRST_KICK_RST;
			cfg_q.cross_kick      <= CROSS_KICK_RST;
			cfg_q.top_threshold   <= TOP_THRESHOLD_RST;
			cfg_q.wrap_threshold  <= WRAP_THRESHOLD_RST;
			cfg_q.motor_idle_code <= MOTOR_IDLE_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_FIRST_KICK:     cfg_q.first_kick      <= cfg_data;
				REG_CROSS_KICK:     cfg_q.cross_kick      <= cfg_data;
				REG_TOP_THRESHOLD:  cfg_q.top_threshold   <= cfg_data;
				REG_WRAP_THRESHOLD: cfg_q.wrap_threshold  <= cfg_data;
				REG_MOTOR_IDLE:     cfg_q.motor_idle_code <= cfg_data[7:0];
				default:            cfg_q <= cfg_q;
			endcase
		end
	end

	// Input stage: valid flag under reset, payload without.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			action_s1           <= action;
			motor_state_s1      <= motor_state;
			encoder_position_s1 <= encoder_position;
			bottom_position_s1  <= bottom_position;
			motor_position_s1   <= motor_position;
		end
	end

	psuk_step #(
		.ENCODER_BITS(ENCODER_BITS)
	) u_step (
		.cfg              (cfg_q),
		.mode             (mode_q),
		.last_offset      (last_offset_q),
		.action           (action_s1),
		.motor_state      (motor_state_s1),
		.encoder_position (encoder_position_s1),
		.bottom_position  (bottom_position_s1),
		.motor_position   (motor_position_s1),
		.mode_nxt         (mode_nxt),
		.offset_upd       (offset_upd),
		.offset           (offset),
		.move_command     (res_move),
		.target_position  (res_target),
		.switch_mode      (res_switch)
	);

	// State commits in the same cycle as the result is loaded, so the next
	// sample already sees it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_RST;
			last_offset_q <= '0;
		end else if (adv) begin
			mode_q <= mode_nxt;
			if (offset_upd) begin
				last_offset_q <= offset;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			move_command_q    <= res_move;
			target_position_q <= res_target;
			switch_mode_q     <= res_switch;
		end
	end

	assign out_valid       = out_valid_q;
	assign move_command    = move_command_q;
	assign target_position = target_position_q;
	assign switch_mode     = switch_mode_q;

	// A hand-over never comes with a move.
	`PSUK_ASSERT_IMPL(a_switch_no_move, clk, arst_n, out_valid_q && switch_mode_q, !move_command_q)
	// Without a move the target reads zero.
	`PSUK_ASSERT_IMPL(a_idle_target_zero, clk, arst_n, out_valid_q && !move_command_q, target_position_q == '0)
	// A hand-over result leaves the block in the finished mode.
	`PSUK_ASSERT_NEXT(a_switch_sets_finished, clk, arst_n, adv && res_switch, mode_q.finished)
	// The input side only stalls with a sample held in the input stage.
	`PSUK_ASSERT_IMPL(a_stall_needs_sample, clk, arst_n, in_stall, valid_s1 && out_valid_q)

endmodule
